/* design/hsu_pkg.sv */
`default_nettype none

package hsu_pkg;

  // Default store capacity
  localparam int MAX_ITEMS_DEF = 64;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;

endpackage

`default_nettype wire

/* design/heap_sorter_unit.sv */
`default_nettype none

// Heap sorter. Pulse start with in_value/in_last while busy is low to hand over
// one element. Loads can come back to back, and busy stays low between loads.
// A transaction with in_last high closes the set: busy rises and the block
// sorts the stored elements with a binary max-heap. Sorting runs on one
// compare unit and a two-read, one-write store. Each sift first reads its
// start node, then at each level reads both children and moves the larger
// one up. The heap is built first, then n-1 extractions follow. Results
// then come out in ascending order, one per cycle, each
// marked by a single-cycle out_valid. The receiver cannot hold results off,
// so it must take every strobe. out_final_res marks the last result of the
// run. out_overflow is set on every result of a run for which elements
// beyond MAX_ITEMS were dropped. busy falls with the last result, so the
// first element of the next set can be handed over in that same cycle. The
// store needs no clearing after reset.
module heap_sorter_unit #(
  parameter int MAX_ITEMS = hsu_pkg::MAX_ITEMS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire hsu_pkg::value_t in_value,
  input  wire logic           in_last,
  output logic                out_valid,
  output hsu_pkg::value_t     out_sorted_value,
  output hsu_pkg::pos_t       out_position,
  output logic                out_final_res,
  output logic                out_overflow
);

  localparam int CW = $clog2(MAX_ITEMS + 1);  // one-based index / count
  localparam int AW = $clog2(MAX_ITEMS);      // store address

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD,
    S_NV,
    S_RD,
    S_CMP,
    S_EXRD,
    S_EXWR,
    S_OUT
  } state_t;

  typedef logic [CW-1:0] idx_t;
  typedef logic [AW-1:0] addr_t;

  state_t            state_r, state_nxt;
  idx_t              count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic              extract_r, extract_nxt;
  idx_t              k_r, k_nxt;
  idx_t              node_r, node_nxt;
  idx_t              size_r, size_nxt;
  idx_t              oidx_r, oidx_nxt;
  hsu_pkg::value_t   nv_r, nv_nxt;
  logic              out_valid_r, out_valid_nxt;
  hsu_pkg::pos_t     out_pos_r, out_pos_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // Store ports
  hsu_pkg::value_t   mem [MAX_ITEMS];
  hsu_pkg::value_t   rd_a_r, rd_b_r;
  addr_t             ra_a, ra_b, wa;
  hsu_pkg::value_t   wd;
  logic              we;

  // Sift helpers
  logic [CW:0]       lc, rc;
  idx_t              node_m1, k_m1, cnt_p1;
  logic              rc_ok, pick_r;
  hsu_pkg::value_t   big_v;
  logic [CW:0]       big_i;
  logic              finish;

  assign lc      = {node_r, 1'b0};
  assign rc      = lc + (CW+1)'(1);
  assign node_m1 = node_r - idx_t'(1);
  assign k_m1    = k_r - idx_t'(1);
  assign cnt_p1  = count_r + idx_t'(1);
  assign rc_ok   = rc <= {1'b0, size_r};
  assign pick_r  = rc_ok && (rd_b_r > rd_a_r);
  assign big_v   = pick_r ? rd_b_r : rd_a_r;
  assign big_i   = pick_r ? rc : lc;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    extract_nxt   = extract_r;
    k_nxt         = k_r;
    node_nxt      = node_r;
    size_nxt      = size_r;
    oidx_nxt      = oidx_r;
    nv_nxt        = nv_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    ra_a          = AW'(k_m1);
    ra_b          = AW'(k_m1);
    wa            = AW'(node_m1);
    wd            = nv_r;
    we            = 1'b0;
    finish        = 1'b0;

    case (state_r)
      S_IDLE: begin
        // Store the element or note the drop
        if (start) begin
          if (count_r < idx_t'(MAX_ITEMS)) begin
            we        = 1'b1;
            wa        = AW'(count_r);
            wd        = in_value;
            count_nxt = cnt_p1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            if (count_nxt >= idx_t'(2)) begin
              k_nxt       = count_nxt >> 1;
              extract_nxt = 1'b0;
              state_nxt   = S_LD;
            end else begin
              oidx_nxt  = '0;
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_LD: begin
        // Read the node that starts a build sift
        ra_a      = AW'(k_m1);
        node_nxt  = k_r;
        size_nxt  = count_r;
        state_nxt = S_NV;
      end
      S_NV: begin
        nv_nxt    = rd_a_r;
        state_nxt = S_RD;
      end
      S_RD: begin
        // Fetch both children, or stop at a leaf
        if (lc > {1'b0, size_r}) begin
          finish = 1'b1;
        end else begin
          ra_a      = AW'(lc - (CW+1)'(1));
          ra_b      = AW'(rc - (CW+1)'(1));
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // Move the larger child up, or settle the held value here
        if (big_v > nv_r) begin
          we        = 1'b1;
          wa        = AW'(node_m1);
          wd        = big_v;
          node_nxt  = CW'(big_i);
          state_nxt = S_RD;
        end else begin
          finish = 1'b1;
        end
      end
      S_EXRD: begin
        ra_a      = '0;
        ra_b      = AW'(k_m1);
        state_nxt = S_EXWR;
      end
      S_EXWR: begin
        // Park the maximum at the tail, sift the old tail from the root
        we        = 1'b1;
        wa        = AW'(k_m1);
        wd        = rd_a_r;
        nv_nxt    = rd_b_r;
        node_nxt  = idx_t'(1);
        size_nxt  = k_m1;
        state_nxt = S_RD;
      end
      S_OUT: begin
        // Stream the sorted store out
        ra_a          = AW'(oidx_r);
        out_valid_nxt = 1'b1;
        out_pos_nxt   = hsu_pkg::POS_W'(oidx_r);
        out_final_nxt = oidx_r == (count_r - idx_t'(1));
        out_ovf_nxt   = drop_r;
        if (oidx_r == (count_r - idx_t'(1))) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          oidx_nxt = oidx_r + idx_t'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Write the held value back and advance to the next sift or to the output phase
    if (finish) begin
      we = 1'b1;
      wa = AW'(node_m1);
      wd = nv_r;
      if (!extract_r) begin
        if (k_r == idx_t'(1)) begin
          k_nxt       = count_r;
          extract_nxt = 1'b1;
          state_nxt   = S_EXRD;
        end else begin
          k_nxt     = k_m1;
          state_nxt = S_LD;
        end
      end else begin
        if (k_r == idx_t'(2)) begin
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          k_nxt     = k_m1;
          state_nxt = S_EXRD;
        end
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    extract_r   <= extract_nxt;
    k_r         <= k_nxt;
    node_r      <= node_nxt;
    size_r      <= size_nxt;
    oidx_r      <= oidx_nxt;
    nv_r        <= nv_nxt;
    out_pos_r   <= out_pos_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Heap store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_sorted_value = rd_a_r;
  assign out_position     = out_pos_r;
  assign out_final_res    = out_final_r;
  assign out_overflow     = out_ovf_r;

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= idx_t'(MAX_ITEMS))
    else $error("element count above capacity");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_OUT))
    else $error("result strobe outside the output phase");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy)
    else $error("closing transaction did not start a sort");

  // A new set may already load one element alongside the final result
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |=> (!out_valid && count_r <= idx_t'(1) && !drop_r))
    else $error("run did not end after its final result");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && we) |-> start)
    else $error("store written while idle without a transaction");

endmodule

`default_nettype wire

/* test/heap_sorter_unit_test.sv */
`timescale 1ns / 100ps

module heap_sorter_unit_test;

  localparam int CAPACITY     = hsu_pkg::MAX_ITEMS_DEF;
  localparam int DIR_ROWS     = 20;
  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 32;
  localparam int REPORT_LIMIT = 10;

  localparam hsu_pkg::value_t INT_MIN  = 32'sh8000_0000;
  localparam hsu_pkg::value_t INT_MAX  = 32'sh7fff_ffff;
  localparam hsu_pkg::value_t MINUS_1  = 32'shffff_ffff;

  // One sorted element as it leaves the block
  typedef struct packed {
    hsu_pkg::value_t value;
    hsu_pkg::pos_t   position;
    logic            final_res;
    logic            overflow;
  } sorted_elem_t;

  // Directed row; exp_value is typed in for single-element sets only
  typedef struct packed {
    hsu_pkg::value_t value;
    logic            last;
    logic            pinned;
    hsu_pkg::value_t exp_value;
  } dir_row_t;

  typedef struct packed {
    logic            pinned;
    hsu_pkg::value_t exp_value;
  } element_tag_t;

  logic            clk;
  logic            rst_n    = 1'b0;
  logic            start    = 1'b0;
  hsu_pkg::value_t in_value = '0;
  logic            in_last  = 1'b0;
  logic            busy;
  logic            out_valid;
  hsu_pkg::value_t out_sorted_value;
  hsu_pkg::pos_t   out_position;
  logic            out_final_res;
  logic            out_overflow;

  heap_sorter_unit #(
    .MAX_ITEMS(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_sorted_value(out_sorted_value),
    .out_position(out_position),
    .out_final_res(out_final_res),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow of the block: elements of the open set and the dropped flag
  hsu_pkg::value_t set_elems_q[$];
  logic            set_dropped = 1'b0;
  sorted_elem_t    sorted_expect_q[$];
  element_tag_t    element_tag_q[$];
  dir_row_t        directed_rows [DIR_ROWS];
  int              mismatch_count = 0;
  int              quiet_cycles = 0;
  int              items_sent = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // Store one element; on the closing element sort the set and queue the run
  task automatic absorb_element(input hsu_pkg::value_t v, input logic last,
                                input element_tag_t tag);
    hsu_pkg::value_t ordered [CAPACITY];
    hsu_pkg::value_t hold;
    sorted_elem_t    elem;
    int              n;
    int              i;
    int              j;
    if (set_elems_q.size() < CAPACITY) begin
      set_elems_q.push_back(v);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      n = set_elems_q.size();
      if (tag.pinned) begin
        elem = '{value: tag.exp_value, position: '0, final_res: 1'b1, overflow: 1'b0};
        sorted_expect_q.push_back(elem);
      end else begin
        for (i = 0; i < n; i++) begin
          ordered[i] = set_elems_q[i];
        end
        // insertion sort, ascending by signed value
        for (i = 1; i < n; i++) begin
          hold = ordered[i];
          j = i - 1;
          while (j >= 0 && ordered[j] > hold) begin
            ordered[j + 1] = ordered[j];
            j--;
          end
          ordered[j + 1] = hold;
        end
        for (i = 0; i < n; i++) begin
          elem.value     = ordered[i];
          elem.position  = hsu_pkg::pos_t'(i);
          elem.final_res = (i == n - 1);
          elem.overflow  = set_dropped;
          sorted_expect_q.push_back(elem);
        end
      end
      set_elems_q.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Watch both channels, check results, and time out on a stalled run
  always @(posedge clk) begin : monitor
    element_tag_t tag;
    sorted_elem_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (start && !busy) begin
        tag = element_tag_q.pop_front();
        absorb_element(in_value, in_last, tag);
        quiet_cycles = 0;
      end
      if (out_valid) begin
        quiet_cycles = 0;
        if (sorted_expect_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value=%0d pos=%0d final=%0b ovf=%0b",
                                  out_sorted_value, out_position, out_final_res,
                                  out_overflow));
        end else begin
          want = sorted_expect_q.pop_front();
          if (out_sorted_value !== want.value || out_position !== want.position ||
              out_final_res !== want.final_res || out_overflow !== want.overflow) begin
            flag_mismatch($sformatf(
              "expected value=%0d pos=%0d final=%0b ovf=%0b, got value=%0d pos=%0d final=%0b ovf=%0b",
              want.value, want.position, want.final_res, want.overflow,
              out_sorted_value, out_position, out_final_res, out_overflow));
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Hand over one element, then idle for a while depending on the phase
  task automatic send_element(input hsu_pkg::value_t v, input logic last, input logic pinned,
                              input hsu_pkg::value_t exp_value);
    int idle_pct;
    int gap;
    element_tag_q.push_back('{pinned: pinned, exp_value: exp_value});
    start    <= 1'b1;
    in_value <= v;
    in_last  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (items_sent < 100) idle_pct = 29;
    else if (items_sent < 200) idle_pct = 80;
    else idle_pct = 0;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start    <= 1'b0;
      in_value <= hsu_pkg::value_t'($urandom);
      in_last  <= 1'(($urandom));
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic hsu_pkg::value_t random_value();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return INT_MAX;
      2, 3: return hsu_pkg::value_t'($signed($urandom_range(0, 7)) - 4);
      default: return hsu_pkg::value_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int i;
    int k;
    int set_idx;
    int set_len;
    directed_rows = '{
      // single-element sets at the extremes
      '{INT_MIN, 1'b1, 1'b1, INT_MIN},
      '{INT_MAX, 1'b1, 1'b1, INT_MAX},
      '{MINUS_1, 1'b1, 1'b1, MINUS_1},
      '{32'sd0,  1'b1, 1'b1, 32'sd0},
      // extremes mixed with equal values
      '{INT_MAX, 1'b0, 1'b0, 32'sd0},
      '{INT_MIN, 1'b0, 1'b0, 32'sd0},
      '{32'sd5,  1'b0, 1'b0, 32'sd0},
      '{MINUS_1, 1'b0, 1'b0, 32'sd0},
      '{32'sd5,  1'b0, 1'b0, 32'sd0},
      '{32'sd0,  1'b0, 1'b0, 32'sd0},
      '{INT_MIN, 1'b0, 1'b0, 32'sd0},
      '{INT_MAX, 1'b0, 1'b0, 32'sd0},
      '{32'sd1,  1'b1, 1'b0, 32'sd0},
      // pairs already ordered and reversed
      '{-32'sd3, 1'b0, 1'b0, 32'sd0},
      '{32'sd3,  1'b1, 1'b0, 32'sd0},
      '{32'sd3,  1'b0, 1'b0, 32'sd0},
      '{-32'sd3, 1'b1, 1'b0, 32'sd0},
      // alternating bit patterns
      '{32'shaaaa_aaaa, 1'b0, 1'b0, 32'sd0},
      '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
      '{32'sh1234_5678, 1'b1, 1'b0, 32'sd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      send_element(directed_rows[i].value, directed_rows[i].last,
                   directed_rows[i].pinned, directed_rows[i].exp_value);
    end

    // Lead with sets around capacity, then mostly short sets
    set_idx = 0;
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      case (set_idx)
        0: set_len = CAPACITY + 2;
        1: set_len = CAPACITY;
        2: set_len = CAPACITY + 1;
        default: begin
          if ($urandom_range(0, 19) == 0) set_len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
          else set_len = $urandom_range(1, 10);
        end
      endcase
      for (k = 0; k < set_len; k++) begin
        send_element(random_value(), k == set_len - 1, 1'b0, 32'sd0);
      end
      set_idx++;
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (element_tag_q.size() != 0 || sorted_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += sorted_expect_q.size();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/hsu_pkg.sv
design/heap_sorter_unit.sv
test/heap_sorter_unit_test.sv
